// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, skipped while in reset.
`define ZZTI_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("zzti check failed");

// Implication in the next cycle, skipped while in reset.
`define ZZTI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("zzti check failed");

// Checked at every edge, reset included.
`define ZZTI_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) (cond)) \
        else $error("zzti check failed");

`endif

// File: rtl/zzti_pkg.sv
// Shared widths and reset constants for the zigzag transposition index.
package zzti_pkg;
    localparam int CHAR_W      = 8;
    localparam int ROW_W       = 13;
    localparam int PERIOD_W    = ROW_W + 1;
    localparam int DEF_MAX_LEN = 4096;
    localparam logic [ROW_W-1:0] ROW_RESET = 13'd3;
endpackage

// File: rtl/zigzag_transposition_index.sv
// Throughput: one transfer per cycle; one input register, one restoring divide
// stage per length bit, three mapping stages. The whole pipe holds on output stall.
// Reset: rst_n clears all valid bits asynchronously and loads row_count with 3.
// The divider runs on the rows register directly; write it only while idle.
module zigzag_transposition_index
    import zzti_pkg::*;
#(
    parameter int MAX_LEN = DEF_MAX_LEN
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 row_count_we,
    input  logic [ROW_W-1:0]     row_count_wdata,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // char_in, char_position, message_length, zero fill
    input  logic [((CHAR_W+$clog2(MAX_LEN)+$clog2(MAX_LEN+1)+7)/8)*8-1:0] s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // char_out, dest_position, zero fill
    output logic [((CHAR_W+$clog2(MAX_LEN)+7)/8)*8-1:0] m_axis_tdata,
    // position_ok
    output logic                 m_axis_tuser
);
    localparam int PW    = $clog2(MAX_LEN);
    localparam int LW    = $clog2(MAX_LEN + 1);
    localparam int SW    = CHAR_W + PW + 2;
    localparam int CMP_W = (LW > ROW_W) ? LW : ROW_W;
    localparam int OUT_W = ((CHAR_W + PW + 7) / 8) * 8;

    logic [ROW_W-1:0]    row_count_reg;
    logic [ROW_W-1:0]    rows_eff;
    logic [PERIOD_W-1:0] period;
    logic                adv;

    logic [CHAR_W-1:0]   in_char;
    logic [PW-1:0]       in_pos;
    logic [LW-1:0]       in_len;
    logic [LW-1:0]       len_sat;
    logic                ok_next;
    logic                use_map_next;

    logic                in_vld_reg;
    logic [SW-1:0]       in_side_reg;
    logic [LW-1:0]       in_len_reg;
    logic [LW-1:0]       in_pos_reg;

    logic                vld_s  [0:LW];
    logic [SW-1:0]       side_s [0:LW];
    logic [LW-1:0]       lnum_s [0:LW];
    logic [PERIOD_W-1:0] lrem_s [0:LW];
    logic [LW-1:0]       lquo_s [0:LW];
    logic [LW-1:0]       pnum_s [0:LW];
    logic [PERIOD_W-1:0] prem_s [0:LW];
    logic [LW-1:0]       pquo_s [0:LW];

    logic                out_vld;
    logic [CHAR_W-1:0]   out_char;
    logic [PW-1:0]       out_dest;
    logic                out_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= ROW_RESET;
        end
        else if (row_count_we)
        begin
            row_count_reg <= row_count_wdata;
        end
    end

    assign rows_eff = (row_count_reg == '0) ? ROW_W'(1) : row_count_reg;
    assign period   = {rows_eff, 1'b0} - PERIOD_W'(2);

    // hold every stage while the output transfer is pending
    assign adv           = !out_vld || m_axis_tready;
    assign s_axis_tready = adv;

    always_comb
    begin
        in_char = s_axis_tdata[CHAR_W-1:0];
        in_pos  = s_axis_tdata[CHAR_W+PW-1:CHAR_W];
        in_len  = s_axis_tdata[CHAR_W+PW+LW-1:CHAR_W+PW];
        len_sat = (CMP_W'(in_len) > CMP_W'(MAX_LEN)) ? LW'(MAX_LEN) : in_len;
        ok_next = CMP_W'(in_pos) < CMP_W'(len_sat);
        use_map_next = ok_next && (rows_eff > ROW_W'(1))
                    && (CMP_W'(rows_eff) < CMP_W'(len_sat));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            in_vld_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            in_side_reg <= {use_map_next, ok_next, in_pos, in_char};
            in_len_reg  <= len_sat;
            in_pos_reg  <= LW'(in_pos);
        end
    end

    assign vld_s[0]  = in_vld_reg;
    assign side_s[0] = in_side_reg;
    assign lnum_s[0] = in_len_reg;
    assign lrem_s[0] = '0;
    assign lquo_s[0] = '0;
    assign pnum_s[0] = in_pos_reg;
    assign prem_s[0] = '0;
    assign pquo_s[0] = '0;

    for (genvar i = 0; i < LW; i++)
    begin : g_div
        zzti_div_stage #(
            .LW  (LW),
            .SW  (SW),
            .BIT (LW - 1 - i)
        ) u_stage (
            .clk         (clk),
            .rst_n       (rst_n),
            .en          (adv),
            .vld_in      (vld_s[i]),
            .side_in     (side_s[i]),
            .period      (period),
            .len_num_in  (lnum_s[i]),
            .len_rem_in  (lrem_s[i]),
            .len_quo_in  (lquo_s[i]),
            .pos_num_in  (pnum_s[i]),
            .pos_rem_in  (prem_s[i]),
            .pos_quo_in  (pquo_s[i]),
            .vld_reg     (vld_s[i+1]),
            .side_reg    (side_s[i+1]),
            .len_num_reg (lnum_s[i+1]),
            .len_rem_reg (lrem_s[i+1]),
            .len_quo_reg (lquo_s[i+1]),
            .pos_num_reg (pnum_s[i+1]),
            .pos_rem_reg (prem_s[i+1]),
            .pos_quo_reg (pquo_s[i+1])
        );
    end

    zzti_map #(
        .LW (LW),
        .PW (PW),
        .SW (SW)
    ) u_map (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .vld_in   (vld_s[LW]),
        .side_in  (side_s[LW]),
        .rows     (rows_eff),
        .period   (period),
        .full     (lquo_s[LW]),
        .tail     (lrem_s[LW]),
        .blk      (pquo_s[LW]),
        .off      (prem_s[LW]),
        .vld_reg  (out_vld),
        .char_reg (out_char),
        .dest_reg (out_dest),
        .ok_reg   (out_ok)
    );

    assign m_axis_tvalid = out_vld;
    assign m_axis_tdata  = OUT_W'({out_dest, out_char});
    assign m_axis_tuser  = out_ok;
endmodule

// File: rtl/zzti_div_stage.sv
// One restoring divide step for length and position by the zigzag period.
module zzti_div_stage
    import zzti_pkg::*;
#(
    parameter int LW  = 13,
    parameter int SW  = 22,
    parameter int BIT = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                vld_in,
    input  logic [SW-1:0]       side_in,
    input  logic [PERIOD_W-1:0] period,
    input  logic [LW-1:0]       len_num_in,
    input  logic [PERIOD_W-1:0] len_rem_in,
    input  logic [LW-1:0]       len_quo_in,
    input  logic [LW-1:0]       pos_num_in,
    input  logic [PERIOD_W-1:0] pos_rem_in,
    input  logic [LW-1:0]       pos_quo_in,
    output logic                vld_reg,
    output logic [SW-1:0]       side_reg,
    output logic [LW-1:0]       len_num_reg,
    output logic [PERIOD_W-1:0] len_rem_reg,
    output logic [LW-1:0]       len_quo_reg,
    output logic [LW-1:0]       pos_num_reg,
    output logic [PERIOD_W-1:0] pos_rem_reg,
    output logic [LW-1:0]       pos_quo_reg
);
    logic [PERIOD_W:0]   len_trial;
    logic [PERIOD_W:0]   pos_trial;
    logic                len_ge;
    logic                pos_ge;
    logic [PERIOD_W-1:0] len_rem_next;
    logic [PERIOD_W-1:0] pos_rem_next;
    logic [LW-1:0]       len_quo_next;
    logic [LW-1:0]       pos_quo_next;

    always_comb
    begin
        len_trial = {len_rem_in, len_num_in[BIT]};
        pos_trial = {pos_rem_in, pos_num_in[BIT]};
        len_ge    = len_trial >= {1'b0, period};
        pos_ge    = pos_trial >= {1'b0, period};
        len_rem_next = len_ge ? PERIOD_W'(len_trial - {1'b0, period})
                              : PERIOD_W'(len_trial);
        pos_rem_next = pos_ge ? PERIOD_W'(pos_trial - {1'b0, period})
                              : PERIOD_W'(pos_trial);
        len_quo_next      = len_quo_in;
        len_quo_next[BIT] = len_ge;
        pos_quo_next      = pos_quo_in;
        pos_quo_next[BIT] = pos_ge;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg    <= side_in;
            len_num_reg <= len_num_in;
            len_rem_reg <= len_rem_next;
            len_quo_reg <= len_quo_next;
            pos_num_reg <= pos_num_in;
            pos_rem_reg <= pos_rem_next;
            pos_quo_reg <= pos_quo_next;
        end
    end
endmodule

// File: rtl/zzti_map.sv
// Three-stage row/column mapping from block and offset to destination index.
module zzti_map
    import zzti_pkg::*;
#(
    parameter int LW = 13,
    parameter int PW = 12,
    parameter int SW = 22
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                vld_in,
    input  logic [SW-1:0]       side_in,
    input  logic [ROW_W-1:0]    rows,
    input  logic [PERIOD_W-1:0] period,
    input  logic [LW-1:0]       full,
    input  logic [PERIOD_W-1:0] tail,
    input  logic [LW-1:0]       blk,
    input  logic [PERIOD_W-1:0] off,
    output logic                vld_reg,
    output logic [CHAR_W-1:0]   char_reg,
    output logic [PW-1:0]       dest_reg,
    output logic                ok_reg
);
    localparam int ADD_W  = LW + 1;
    localparam int CORR_W = PERIOD_W + 1;
    localparam int PROD_W = LW + PERIOD_W;
    localparam int SUM_W  = PROD_W + 1;

    // side layout, low bits up: char, position, ok, use_map
    logic [PERIOD_W-1:0] rows_w;
    logic [PERIOD_W-1:0] row;
    logic                col;
    logic [PERIOD_W-1:0] coef_next;
    logic [ADD_W-1:0]    add_next;
    logic [CORR_W-1:0]   corr_next;
    logic [CORR_W-1:0]   wrap;
    logic [CORR_W-1:0]   two_rows;

    logic                m1_vld_reg;
    logic [SW-1:0]       m1_side_reg;
    logic [LW-1:0]       m1_full_reg;
    logic [PERIOD_W-1:0] m1_coef_reg;
    logic [ADD_W-1:0]    m1_add_reg;
    logic [CORR_W-1:0]   m1_corr_reg;

    logic                m2_vld_reg;
    logic [SW-1:0]       m2_side_reg;
    logic [PROD_W-1:0]   m2_prod_reg;
    logic [CORR_W+ADD_W-1:0] m2_sum_reg;

    logic [SUM_W-1:0]    d_full;
    logic [PW-1:0]       dest_next;

    always_comb
    begin
        rows_w = PERIOD_W'(rows);
        if (off < rows_w)
        begin
            row = off;
            col = 1'b0;
        end
        else
        begin
            row = period - off;
            col = 1'b1;
        end

        if (row == '0)
        begin
            coef_next = '0;
            add_next  = ADD_W'(blk);
        end
        else if (row == rows_w - PERIOD_W'(1))
        begin
            coef_next = PERIOD_W'({rows_w, 1'b0} - (PERIOD_W + 1)'(3));
            add_next  = ADD_W'(blk);
        end
        else
        begin
            coef_next = PERIOD_W'({row, 1'b0} - (PERIOD_W + 1)'(1));
            add_next  = {blk, col};
        end

        // partial final block correction
        two_rows = {rows_w, 1'b0};
        wrap     = CORR_W'(tail) + CORR_W'(row) + CORR_W'(1);
        if (tail < row)
        begin
            corr_next = CORR_W'(tail);
        end
        else if (tail <= rows_w)
        begin
            corr_next = CORR_W'(row);
        end
        else if (wrap > two_rows)
        begin
            corr_next = CORR_W'(row) + (wrap - two_rows);
        end
        else
        begin
            corr_next = CORR_W'(row);
        end
    end

    always_comb
    begin
        d_full    = SUM_W'(m2_prod_reg) + SUM_W'(m2_sum_reg);
        dest_next = m2_side_reg[PW+CHAR_W+1] ? PW'(d_full)
                                             : m2_side_reg[PW+CHAR_W-1:CHAR_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_vld_reg <= 1'b0;
            m2_vld_reg <= 1'b0;
            vld_reg    <= 1'b0;
        end
        else if (en)
        begin
            m1_vld_reg <= vld_in;
            m2_vld_reg <= m1_vld_reg;
            vld_reg    <= m2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_side_reg <= side_in;
            m1_full_reg <= full;
            m1_coef_reg <= coef_next;
            m1_add_reg  <= add_next;
            m1_corr_reg <= corr_next;

            m2_side_reg <= m1_side_reg;
            m2_prod_reg <= PROD_W'(m1_full_reg) * PROD_W'(m1_coef_reg);
            m2_sum_reg  <= (CORR_W + ADD_W)'(m1_add_reg) + (CORR_W + ADD_W)'(m1_corr_reg);

            char_reg <= m2_side_reg[CHAR_W-1:0];
            ok_reg   <= m2_side_reg[PW+CHAR_W];
            dest_reg <= dest_next;
        end
    end
endmodule

// File: rtl/zzti_checker.sv
// Port-level checks for the zigzag transposition index, bound to the top level.
`include "assert_macros.svh"

module zzti_checker #(
    parameter int DATA_W = 24
) (
    input logic              clk,
    input logic              rst_n,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [DATA_W-1:0] m_axis_tdata,
    input logic              m_axis_tuser
);
    // valid may still be unknown at the first edge, before reset has acted
    `ZZTI_ASSERT_ALWAYS(a_reset_quiet, rst_n || (m_axis_tvalid !== 1'b1))
    `ZZTI_ASSERT_IMP(a_ready_follows_out, 1'b1, s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    `ZZTI_ASSERT_NEXT(a_stall_holds, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
endmodule

bind zigzag_transposition_index zzti_checker #(
    .DATA_W ($bits(m_axis_tdata))
) u_zzti_checker (.*);
